@@ hdl/lel_pkg.sv @@
`default_nettype none
package lel_pkg;

  // fixed field widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 12;
  localparam int OUT_W     = 32;

  // default structure sizes
  localparam int BOX_SIZE_DEF = 20;
  localparam int MAX_LINE_DEF = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MIN_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MIN_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SEARCH_END = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SEARCH_DEPTH = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST         = 13'd4096;
  localparam logic [CFG_W-1:0] LEFT_MIN_STEP_RST      = 13'd200;
  localparam logic [CFG_W-1:0] RIGHT_MIN_STEP_RST     = 13'd100;
  localparam logic [PIX_W-1:0] BRIGHT_LEVEL_RST       = 8'd180;
  localparam logic [CFG_W-1:0] LEFT_SEARCH_END_RST    = 13'd700;
  localparam logic [CFG_W-1:0] RIGHT_SEARCH_DEPTH_RST = 13'd720;

  typedef struct packed {
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] left_min_step;
    logic [CFG_W-1:0] right_min_step;
    logic [PIX_W-1:0] bright_level;
    logic [CFG_W-1:0] left_search_end;
    logic [CFG_W-1:0] right_search_depth;
  } cfg_t;

  // per-pixel decisions handed from the box stage to the tracking stage
  typedef struct packed {
    logic             left_ok;
    logic             right_ok;
    logic             first_bright;
    logic             line_end;
    logic             end_bright;
    logic [POS_W-1:0] pos;
  } s1_t;

  typedef struct packed {
    logic             left_found;
    logic [POS_W-1:0] left_position;
    logic             right_found;
    logic [POS_W-1:0] right_position;
  } res_t;

endpackage
`default_nettype wire

@@ hdl/lel_cell.sv @@
`default_nettype none
module lel_cell #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         clr,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  // one tap of the pixel delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= clr ? '0 : din;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lel_box_diff.sv @@
`default_nettype none
module lel_box_diff #(
  parameter int BOX_SIZE = 20,
  parameter int MAX_LINE = 4096,
  parameter int DIFF_W   = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [lel_pkg::PIX_W-1:0]   pixel,
  input  wire logic                        last,
  input  wire lel_pkg::cfg_t               cfg,
  output logic signed [DIFF_W-1:0]         diff,
  output lel_pkg::s1_t                     flags
);
  import lel_pkg::*;

  localparam int DEPTH = 2 * BOX_SIZE;
  localparam int CNT_W = $clog2(MAX_LINE);
  localparam int WW    = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
  localparam int CW    = WW + 1;

  logic [PIX_W-1:0] tap      [DEPTH];
  logic [PIX_W-1:0] chain_in [DEPTH];
  logic [CNT_W-1:0] count;
  logic             fresh;

  logic [WW-1:0]    lw;
  logic [WW-1:0]    w;
  logic [CW-1:0]    p1;
  logic [CNT_W-1:0] j;
  logic             eval;
  logic             line_end;
  logic signed [DIFF_W-1:0] delta;
  logic signed [DIFF_W-1:0] diff_base;
  s1_t              flags_next;

  // chain of pixel cells, cleared after the last pixel of a line
  assign chain_in[0] = pixel;
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign chain_in[k] = tap[k-1];
    end
    lel_cell #(.W(PIX_W)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (accept),
      .clr  (line_end),
      .din  (chain_in[k]),
      .dout (tap[k])
    );
  end

  // clamped line width and candidate window tests
  always_comb begin
    lw = WW'(cfg.line_width);
    if (lw == '0) begin
      w = WW'(1);
    end else if (lw > WW'(MAX_LINE)) begin
      w = WW'(MAX_LINE);
    end else begin
      w = lw;
    end
    p1       = CW'(count) + CW'(1);
    j        = count - CNT_W'(BOX_SIZE);
    eval     = CW'(count) >= CW'(DEPTH);
    line_end = last || (p1 >= CW'(w));

    flags_next.left_ok      = eval && (CW'(j) < CW'(cfg.left_search_end));
    flags_next.right_ok     = eval && (p1 <= CW'(w)) &&
                              (CW'(j) + CW'(cfg.right_search_depth) > CW'(w));
    flags_next.first_bright = (count == '0) && (pixel > cfg.bright_level);
    flags_next.line_end     = line_end;
    flags_next.end_bright   = pixel > cfg.bright_level;
    flags_next.pos          = POS_W'(j);
  end

  // newer box gains the new pixel, the middle pixel moves to the older box
  assign delta = DIFF_W'(pixel) + DIFF_W'(tap[DEPTH-1]) - (DIFF_W'(tap[BOX_SIZE-1]) << 1);
  assign diff_base = fresh ? '0 : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fresh <= 1'b1;
      diff  <= '0;
    end else if (accept) begin
      count <= line_end ? '0 : CNT_W'(p1);
      fresh <= line_end;
      diff  <= diff_base + delta;
    end
  end

  // per-pixel decisions, guarded by the stage valid in the top level
  always_ff @(posedge clk) begin
    if (accept) begin
      flags <= flags_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lel_edge_track.sv @@
`default_nettype none
module lel_edge_track #(
  parameter int DIFF_W = 15
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire lel_pkg::s1_t        flags,
  input  wire logic signed [DIFF_W-1:0] diff,
  input  wire lel_pkg::cfg_t       cfg,
  output lel_pkg::res_t            res
);
  import lel_pkg::*;

  localparam int CMP_W = (DIFF_W > CFG_W + 1) ? DIFF_W : CFG_W + 1;

  logic signed [DIFF_W-1:0] best_rise, best_rise_next;
  logic signed [DIFF_W-1:0] best_fall, best_fall_next;
  logic                     left_found, left_found_next;
  logic [POS_W-1:0]         left_pos, left_pos_next;
  logic                     right_found, right_found_next;
  logic [POS_W-1:0]         right_pos, right_pos_next;

  logic signed [CMP_W-1:0] rise;
  logic signed [CMP_W-1:0] fall;
  logic signed [CMP_W-1:0] left_min;
  logic signed [CMP_W-1:0] right_min;

  // strongest rise on the left, strongest fall on the right
  always_comb begin
    rise      = CMP_W'(diff);
    fall      = -rise;
    left_min  = $signed(CMP_W'(cfg.left_min_step));
    right_min = $signed(CMP_W'(cfg.right_min_step));

    best_rise_next   = best_rise;
    best_fall_next   = best_fall;
    left_found_next  = left_found;
    left_pos_next    = left_pos;
    right_found_next = right_found;
    right_pos_next   = right_pos;

    if (flags.first_bright) begin
      left_found_next = 1'b1;
      left_pos_next   = '0;
    end
    if (flags.left_ok && (rise > left_min) && (rise > CMP_W'(best_rise))) begin
      best_rise_next  = DIFF_W'(rise);
      left_found_next = 1'b1;
      left_pos_next   = flags.pos;
    end
    // ties move the right edge outwards
    if (flags.right_ok && (fall > right_min) && (fall >= CMP_W'(best_fall))) begin
      best_fall_next   = DIFF_W'(fall);
      right_found_next = 1'b1;
      right_pos_next   = flags.pos;
    end

    res.left_found     = left_found_next;
    res.left_position  = left_pos_next;
    res.right_found    = right_found_next || flags.end_bright;
    res.right_position = right_found_next ? right_pos_next : '0;
  end

  // line state, cleared once the line's result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      best_rise   <= '0;
      best_fall   <= '0;
      left_found  <= 1'b0;
      left_pos    <= '0;
      right_found <= 1'b0;
      right_pos   <= '0;
    end else if (fire) begin
      if (flags.line_end) begin
        best_rise   <= '0;
        best_fall   <= '0;
        left_found  <= 1'b0;
        left_pos    <= '0;
        right_found <= 1'b0;
        right_pos   <= '0;
      end else begin
        best_rise   <= best_rise_next;
        best_fall   <= best_fall_next;
        left_found  <= left_found_next;
        left_pos    <= left_pos_next;
        right_found <= right_found_next;
        right_pos   <= right_pos_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/line_edge_locator.sv @@
`default_nettype none
// Edge locator for one scan line: takes one gray pixel per clock on the slave stream and
// returns one request per line with the left and right edge positions. Pixels pass a chain
// of 2*BOX_SIZE delay cells feeding a running box-sum difference (first stage), then a
// tracking stage keeps the strongest rise and fall (second stage). Sustained rate is one
// pixel per clock; a line's result is captured in an output register when its line end
// leaves the first stage and is held there, so input is only held off when a further line
// end reaches the tracking stage while the previous result is still waiting. No clearing
// pass is needed after reset.
module line_edge_locator #(
  parameter int BOX_SIZE = lel_pkg::BOX_SIZE_DEF,
  parameter int MAX_LINE = lel_pkg::MAX_LINE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [lel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lel_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lel_pkg::PIX_W-1:0]     s_tdata,   // [7:0] gray_pixel
  input  wire logic                          s_tlast,   // last_in_line
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] left_found, [12:1] left_position, [13] right_found, [25:14] right_position
  output logic [lel_pkg::OUT_W-1:0]          m_tdata
);
  import lel_pkg::*;

  localparam int DIFF_W = $clog2(BOX_SIZE * 255 + 1) + 1;

  cfg_t                     cfg;
  logic                     accept;
  logic                     s1_valid;
  logic                     s1_adv;
  logic                     out_free;
  s1_t                      s1_flags;
  logic signed [DIFF_W-1:0] s1_diff;
  res_t                     res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width         <= LINE_WIDTH_RST;
      cfg.left_min_step      <= LEFT_MIN_STEP_RST;
      cfg.right_min_step     <= RIGHT_MIN_STEP_RST;
      cfg.bright_level       <= BRIGHT_LEVEL_RST;
      cfg.left_search_end    <= LEFT_SEARCH_END_RST;
      cfg.right_search_depth <= RIGHT_SEARCH_DEPTH_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_LINE_WIDTH:         cfg.line_width         <= cfg_wdata;
        REG_LEFT_MIN_STEP:      cfg.left_min_step      <= cfg_wdata;
        REG_RIGHT_MIN_STEP:     cfg.right_min_step     <= cfg_wdata;
        REG_BRIGHT_LEVEL:       cfg.bright_level       <= cfg_wdata[PIX_W-1:0];
        REG_LEFT_SEARCH_END:    cfg.left_search_end    <= cfg_wdata;
        REG_RIGHT_SEARCH_DEPTH: cfg.right_search_depth <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && (!s1_flags.line_end || out_free);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
    end
  end

  lel_box_diff #(
    .BOX_SIZE (BOX_SIZE),
    .MAX_LINE (MAX_LINE),
    .DIFF_W   (DIFF_W)
  ) u_box_diff (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pixel  (s_tdata),
    .last   (s_tlast),
    .cfg    (cfg),
    .diff   (s1_diff),
    .flags  (s1_flags)
  );

  lel_edge_track #(
    .DIFF_W (DIFF_W)
  ) u_edge_track (
    .clk   (clk),
    .rst   (rst),
    .fire  (s1_adv),
    .flags (s1_flags),
    .diff  (s1_diff),
    .cfg   (cfg),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_flags.line_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.line_end) begin
      m_tdata <= {6'b0, res.right_position, res.right_found,
                  res.left_position, res.left_found};
    end
  end

  // input is held off only by a line end waiting on a full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s1_flags.line_end && m_tvalid && !m_tready))
    else $error("input stalled without a pending line end");

  // a new request follows a line end leaving the first stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_adv && s1_flags.line_end))
    else $error("request raised without a line end");

  // positions read zero where no edge was found
  a_left_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[12:1] == '0))
    else $error("left position set without a left edge");

  a_right_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[13]) |-> (m_tdata[25:14] == '0))
    else $error("right position set without a right edge");

endmodule
`default_nettype wire
